@@ sv/nca_pkg.sv @@
// Shared package for the nearest-centroid assignment block.
// Holds the opcode and register-index codes, the accumulator width and the
// control struct that travels along the cell chain. Depends on nothing.
package nca_pkg;

    localparam int ACC_BITS = 36;
    localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

    localparam int CFG_IDX_BITS = 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTROIDS = 1'b0,
        CFG_DIMS      = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_POINT = 1'b1
    } t_opcode;

    // Control bits of one item as it moves from stage to stage.
    typedef struct packed {
        logic    valid;
        t_opcode op;
        logic    last;
        logic    dim_ok;
    } t_ctl;

endpackage

@@ sv/nca_item_if.sv @@
// Input channel of the nearest-centroid assignment block.
// Valid/ready handshake with the coordinate payload; no package needed.
interface nca_item_if #(
    parameter int SLOT_BITS  = 4,
    parameter int DIM_BITS   = 4,
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [SLOT_BITS-1:0]         centroid_slot;
    logic [DIM_BITS-1:0]          dim_index;
    logic signed [COORD_BITS-1:0] coord_value;
    logic                         last_coord;

    modport source (
        output valid, opcode, centroid_slot, dim_index, coord_value, last_coord,
        input  ready
    );
    modport sink (
        input  valid, opcode, centroid_slot, dim_index, coord_value, last_coord,
        output ready
    );
endinterface

@@ sv/nca_result_if.sv @@
// Result channel of the nearest-centroid assignment block.
// Valid/ready handshake carrying the winning slot and its squared distance.
interface nca_result_if #(
    parameter int SLOT_BITS = 4,
    parameter int DIST_BITS = 36
);
    logic                 valid;
    logic                 ready;
    logic [SLOT_BITS-1:0] nearest_centroid;
    logic [DIST_BITS-1:0] min_distance_sq;

    modport source (
        output valid, nearest_centroid, min_distance_sq,
        input  ready
    );
    modport sink (
        input  valid, nearest_centroid, min_distance_sq,
        output ready
    );
endinterface

@@ sv/nearest_centroid_assign.sv @@
// Top level of the nearest-centroid assignment block (k-means assignment step).
// Depends on nca_pkg, nca_item_if, nca_result_if, nca_ram and nca_cell.
//
//   channel    direction  handshake            payload
//   i_item     in         valid / ready        opcode, centroid_slot, dim_index,
//                                              coord_value, last_coord
//   o_result   out        valid / ready        nearest_centroid, min_distance_sq
//   i_cfg_*    in         write enable only    register index, register data
//
// One item is taken in every cycle while the chain is not stalled. Each item
// walks a chain of MAX_CENTROIDS cells, three register stages per cell (store
// read, square, accumulate and compare); a point's result goes from the last
// cell into the output register.
// Reset is synchronous and active low; it clears the stage valid bits, the
// accumulators and the output valid bit and needs no clearing pass. The chain
// stalls only when a finished result reaches its end while the previous one
// still waits at the output; loads and non-final coordinates never stall it.
module nearest_centroid_assign #(
    parameter  int MAX_CENTROIDS = 16,
    parameter  int MAX_DIMS      = 16,
    parameter  int COORD_BITS    = 16,
    localparam int SLOT_BITS     = $clog2(MAX_CENTROIDS),
    localparam int CNT_C_BITS    = $clog2(MAX_CENTROIDS + 1),
    localparam int CNT_D_BITS    = $clog2(MAX_DIMS + 1),
    localparam int CFG_BITS      = (CNT_C_BITS > CNT_D_BITS) ? CNT_C_BITS : CNT_D_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    nca_item_if.sink                        i_item,
    nca_result_if.source                    o_result,
    input  logic                            i_cfg_we,
    input  logic [nca_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]             i_cfg_data
);
    import nca_pkg::*;

    localparam int DIM_BITS = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CMP_BITS = (DIM_BITS > CNT_D_BITS) ? DIM_BITS : CNT_D_BITS;

    // Configuration registers and their clamped working values. A zero acts
    // as one, and anything above MAX_CENTROIDS or MAX_DIMS acts as that maximum.
    logic [CNT_C_BITS-1:0] r_ncent;
    logic [CNT_D_BITS-1:0] r_ndims;
    logic [CNT_C_BITS-1:0] ncent;
    logic [CNT_D_BITS-1:0] ndims;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncent <= CNT_C_BITS'(1);
            r_ndims <= CNT_D_BITS'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CENTROIDS: r_ncent <= i_cfg_data[CNT_C_BITS-1:0];
                CFG_DIMS:      r_ndims <= i_cfg_data[CNT_D_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        ncent = r_ncent;
        if (r_ncent == '0) begin
            ncent = CNT_C_BITS'(1);
        end else if (r_ncent > CNT_C_BITS'(MAX_CENTROIDS)) begin
            ncent = CNT_C_BITS'(MAX_CENTROIDS);
        end
        ndims = r_ndims;
        if (r_ndims == '0) begin
            ndims = CNT_D_BITS'(1);
        end else if (r_ndims > CNT_D_BITS'(MAX_DIMS)) begin
            ndims = CNT_D_BITS'(MAX_DIMS);
        end
    end

    // Links between cells; link k feeds cell k, the last link is the tail.
    t_ctl                         c_ctl      [0:MAX_CENTROIDS];
    logic [SLOT_BITS-1:0]         c_slot     [0:MAX_CENTROIDS];
    logic [DIM_BITS-1:0]          c_dim      [0:MAX_CENTROIDS];
    logic signed [COORD_BITS-1:0] c_coord    [0:MAX_CENTROIDS];
    logic [CNT_C_BITS-1:0]        c_ncent    [0:MAX_CENTROIDS];
    logic [SLOT_BITS-1:0]         c_best_idx [0:MAX_CENTROIDS];
    logic [ACC_BITS-1:0]          c_best_d   [0:MAX_CENTROIDS];

    logic advance;
    logic tail_result;
    logic r_o_valid;
    logic [SLOT_BITS-1:0] r_o_nearest;
    logic [ACC_BITS-1:0]  r_o_dist;

    // The incoming item enters cell zero directly. The dimension check and
    // the centroid count are fixed here and travel with the item.
    always_comb begin
        c_ctl[0].valid  = i_item.valid;
        c_ctl[0].op     = t_opcode'(i_item.opcode);
        c_ctl[0].last   = i_item.last_coord;
        c_ctl[0].dim_ok = CMP_BITS'(i_item.dim_index) < CMP_BITS'(ndims);
        c_slot[0]       = i_item.centroid_slot;
        c_dim[0]        = i_item.dim_index;
        c_coord[0]      = i_item.coord_value;
        c_ncent[0]      = ncent;
        c_best_idx[0]   = '0;
        c_best_d[0]     = '0;
    end

    for (genvar k = 0; k < MAX_CENTROIDS; k++) begin : g_cell
        nca_cell #(
            .CELL_IDX      (k),
            .MAX_CENTROIDS (MAX_CENTROIDS),
            .MAX_DIMS      (MAX_DIMS),
            .COORD_BITS    (COORD_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_advance  (advance),
            .i_ctl      (c_ctl[k]),
            .i_slot     (c_slot[k]),
            .i_dim      (c_dim[k]),
            .i_coord    (c_coord[k]),
            .i_ncent    (c_ncent[k]),
            .i_best_idx (c_best_idx[k]),
            .i_best_d   (c_best_d[k]),
            .o_ctl      (c_ctl[k+1]),
            .o_slot     (c_slot[k+1]),
            .o_dim      (c_dim[k+1]),
            .o_coord    (c_coord[k+1]),
            .o_ncent    (c_ncent[k+1]),
            .o_best_idx (c_best_idx[k+1]),
            .o_best_d   (c_best_d[k+1])
        );
    end

    // A point's last item at the tail carries the finished search. The chain
    // holds only when that result cannot move into the output register.
    assign tail_result = c_ctl[MAX_CENTROIDS].valid &&
                         (c_ctl[MAX_CENTROIDS].op == OP_POINT) &&
                         c_ctl[MAX_CENTROIDS].last;
    assign advance     = !tail_result || !r_o_valid || o_result.ready;
    assign i_item.ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance && tail_result) begin
            r_o_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && tail_result) begin
            r_o_nearest <= c_best_idx[MAX_CENTROIDS];
            r_o_dist    <= c_best_d[MAX_CENTROIDS];
        end
    end

    assign o_result.valid            = r_o_valid;
    assign o_result.nearest_centroid = r_o_nearest;
    assign o_result.min_distance_sq  = r_o_dist;

endmodule

@@ sv/nca_ram.sv @@
// Generic single-address RAM with a registered read port.
// Used for each cell's slice of the centroid store; no dependencies.
module nca_ram #(
    parameter  int WIDTH     = 16,
    parameter  int DEPTH     = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [WIDTH-1:0]     i_wdata,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/nca_cell.sv @@
// One cell of the centroid chain: owns one centroid's coordinates and its
// distance accumulator, and passes items plus the running best match on.
// Depends on nca_pkg and nca_ram.
module nca_cell #(
    parameter  int CELL_IDX      = 0,
    parameter  int MAX_CENTROIDS = 16,
    parameter  int MAX_DIMS      = 16,
    parameter  int COORD_BITS    = 16,
    localparam int SLOT_BITS     = $clog2(MAX_CENTROIDS),
    localparam int DIM_BITS      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
    localparam int CNT_C_BITS    = $clog2(MAX_CENTROIDS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  nca_pkg::t_ctl                i_ctl,
    input  logic [SLOT_BITS-1:0]         i_slot,
    input  logic [DIM_BITS-1:0]          i_dim,
    input  logic signed [COORD_BITS-1:0] i_coord,
    input  logic [CNT_C_BITS-1:0]        i_ncent,
    input  logic [SLOT_BITS-1:0]         i_best_idx,
    input  logic [nca_pkg::ACC_BITS-1:0] i_best_d,
    output nca_pkg::t_ctl                o_ctl,
    output logic [SLOT_BITS-1:0]         o_slot,
    output logic [DIM_BITS-1:0]          o_dim,
    output logic signed [COORD_BITS-1:0] o_coord,
    output logic [CNT_C_BITS-1:0]        o_ncent,
    output logic [SLOT_BITS-1:0]         o_best_idx,
    output logic [nca_pkg::ACC_BITS-1:0] o_best_d
);
    import nca_pkg::*;

    localparam int SQ_BITS  = 2 * (COORD_BITS + 1);
    localparam int SUM_BITS = ((SQ_BITS > ACC_BITS) ? SQ_BITS : ACC_BITS) + 1;
    localparam logic [SLOT_BITS-1:0]  MY_SLOT   = SLOT_BITS'(CELL_IDX);
    localparam logic [CNT_C_BITS-1:0] MY_COUNT  = CNT_C_BITS'(CELL_IDX);
    localparam logic [DIM_BITS:0]     DIM_LIMIT = (DIM_BITS + 1)'(MAX_DIMS);

    // Stage A is the incoming item: write on a load to this slot, read on every advance.
    logic                  ram_we;
    logic [COORD_BITS-1:0] ram_rdata;

    assign ram_we = i_advance && i_ctl.valid && (i_ctl.op == OP_LOAD) &&
                    (i_slot == MY_SLOT) && ({1'b0, i_dim} < DIM_LIMIT);

    nca_ram #(
        .WIDTH (COORD_BITS),
        .DEPTH (MAX_DIMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (i_advance),
        .i_addr  (i_dim),
        .i_wdata (i_coord),
        .o_rdata (ram_rdata)
    );

    // Stage B: difference and square.
    t_ctl                         r_b_ctl;
    logic [SLOT_BITS-1:0]         r_b_slot;
    logic [DIM_BITS-1:0]          r_b_dim;
    logic signed [COORD_BITS-1:0] r_b_coord;
    logic [CNT_C_BITS-1:0]        r_b_ncent;
    logic [SLOT_BITS-1:0]         r_b_best_idx;
    logic [ACC_BITS-1:0]          r_b_best_d;

    logic signed [COORD_BITS:0]   diff;
    logic signed [SQ_BITS-1:0]    prod;

    assign diff = {r_b_coord[COORD_BITS-1], r_b_coord} -
                  {ram_rdata[COORD_BITS-1], ram_rdata};
    assign prod = diff * diff;

    // Stage C: accumulate with saturation and compare against the best so far.
    t_ctl                         r_c_ctl;
    logic [SLOT_BITS-1:0]         r_c_slot;
    logic [DIM_BITS-1:0]          r_c_dim;
    logic signed [COORD_BITS-1:0] r_c_coord;
    logic [CNT_C_BITS-1:0]        r_c_ncent;
    logic [SLOT_BITS-1:0]         r_c_best_idx;
    logic [ACC_BITS-1:0]          r_c_best_d;
    logic [SQ_BITS-1:0]           r_c_sq;

    logic [ACC_BITS-1:0]          r_acc;
    logic [ACC_BITS-1:0]          n_acc;
    logic [ACC_BITS-1:0]          acc_sum;
    logic [SUM_BITS-1:0]          wide_sum;
    logic                         active;
    logic                         is_point;
    logic [SLOT_BITS-1:0]         n_best_idx;
    logic [ACC_BITS-1:0]          n_best_d;

    // Output register toward the next cell.
    t_ctl                         r_o_ctl;
    logic [SLOT_BITS-1:0]         r_o_slot;
    logic [DIM_BITS-1:0]          r_o_dim;
    logic signed [COORD_BITS-1:0] r_o_coord;
    logic [CNT_C_BITS-1:0]        r_o_ncent;
    logic [SLOT_BITS-1:0]         r_o_best_idx;
    logic [ACC_BITS-1:0]          r_o_best_d;

    always_comb begin
        active   = MY_COUNT < r_c_ncent;
        is_point = r_c_ctl.valid && (r_c_ctl.op == OP_POINT);
        wide_sum = SUM_BITS'(r_acc) + SUM_BITS'(r_c_sq);
        if (wide_sum > SUM_BITS'(ACC_MAX)) begin
            acc_sum = ACC_MAX;
        end else begin
            acc_sum = wide_sum[ACC_BITS-1:0];
        end
        if (active && r_c_ctl.dim_ok) begin
            n_best_d = acc_sum;
        end else begin
            n_best_d = r_acc;
        end
        // The accumulator after this item; a point's last item clears it.
        if (is_point && r_c_ctl.last) begin
            n_acc = '0;
        end else if (is_point) begin
            n_acc = n_best_d;
        end else begin
            n_acc = r_acc;
        end
        // Cell zero opens the search; later cells win only when strictly
        // closer, so ties stay with the lowest slot.
        n_best_idx = MY_SLOT;
        if (CELL_IDX != 0) begin
            if (!(active && (n_best_d < r_c_best_d))) begin
                n_best_idx = r_c_best_idx;
                n_best_d   = r_c_best_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
            r_c_ctl <= '0;
            r_o_ctl <= '0;
            r_acc   <= '0;
        end else if (i_advance) begin
            r_b_ctl <= i_ctl;
            r_c_ctl <= r_b_ctl;
            r_o_ctl <= r_c_ctl;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_b_slot     <= i_slot;
            r_b_dim      <= i_dim;
            r_b_coord    <= i_coord;
            r_b_ncent    <= i_ncent;
            r_b_best_idx <= i_best_idx;
            r_b_best_d   <= i_best_d;

            r_c_slot     <= r_b_slot;
            r_c_dim      <= r_b_dim;
            r_c_coord    <= r_b_coord;
            r_c_ncent    <= r_b_ncent;
            r_c_best_idx <= r_b_best_idx;
            r_c_best_d   <= r_b_best_d;
            r_c_sq       <= unsigned'(prod);

            r_o_slot     <= r_c_slot;
            r_o_dim      <= r_c_dim;
            r_o_coord    <= r_c_coord;
            r_o_ncent    <= r_c_ncent;
            r_o_best_idx <= n_best_idx;
            r_o_best_d   <= n_best_d;
        end
    end

    assign o_ctl      = r_o_ctl;
    assign o_slot     = r_o_slot;
    assign o_dim      = r_o_dim;
    assign o_coord    = r_o_coord;
    assign o_ncent    = r_o_ncent;
    assign o_best_idx = r_o_best_idx;
    assign o_best_d   = r_o_best_d;

endmodule

@@ sv/nca_checker.sv @@
// Port-level assertions for nearest_centroid_assign and the bind that
// attaches them. Depends on nca_pkg and the top level's ports.
module nca_checker #(
    parameter  int MAX_CENTROIDS = 16,
    parameter  int MAX_DIMS      = 16,
    parameter  int COORD_BITS    = 16,
    localparam int SLOT_BITS     = $clog2(MAX_CENTROIDS),
    localparam int CNT_C_BITS    = $clog2(MAX_CENTROIDS + 1),
    localparam int CNT_D_BITS    = $clog2(MAX_DIMS + 1),
    localparam int CFG_BITS      = (CNT_C_BITS > CNT_D_BITS) ? CNT_C_BITS : CNT_D_BITS
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic signed [COORD_BITS-1:0]     i_in_coord,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [SLOT_BITS-1:0]             i_out_nearest,
    input logic [nca_pkg::ACC_BITS-1:0]     i_out_dist,
    input logic                             i_cfg_we,
    input logic [nca_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input logic [CFG_BITS-1:0]              i_cfg_data
);
    import nca_pkg::*;

    // Shadow of the centroid count as written through the port.
    logic [CNT_C_BITS-1:0] r_ncent;
    logic [CNT_C_BITS-1:0] limit;
    logic                  in_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncent <= CNT_C_BITS'(1);
        end else if (i_cfg_we && (i_cfg_index == CFG_CENTROIDS)) begin
            r_ncent <= i_cfg_data[CNT_C_BITS-1:0];
        end
    end

    always_comb begin
        limit = r_ncent;
        if (r_ncent == '0) begin
            limit = CNT_C_BITS'(1);
        end else if (r_ncent > CNT_C_BITS'(MAX_CENTROIDS)) begin
            limit = CNT_C_BITS'(MAX_CENTROIDS);
        end
        in_seen = i_in_valid && (i_in_coord == i_in_coord);
    end

    // With nothing waiting at the output the chain never stalls.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid && in_seen) |-> i_in_ready)
        else $error("input not ready although no result is pending");

    // A result that is not taken keeps its payload.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_nearest) && $stable(i_out_dist)))
        else $error("pending result changed or vanished");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // The winner is always one of the centroids in use.
    a_index_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (CNT_C_BITS'(i_out_nearest) < limit))
        else $error("nearest centroid outside the slots in use");

endmodule

bind nearest_centroid_assign nca_checker #(
    .MAX_CENTROIDS (MAX_CENTROIDS),
    .MAX_DIMS      (MAX_DIMS),
    .COORD_BITS    (COORD_BITS)
) u_nca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_in_coord    (i_item.coord_value),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_nearest (o_result.nearest_centroid),
    .i_out_dist    (o_result.min_distance_sq),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_index   (i_cfg_index),
    .i_cfg_data    (i_cfg_data)
);
